// File: rtl/id3fw_pkg.sv
// shared types and constants for the id3v2 frame walker
package id3fw_pkg;

	// default clamp on the tag length
	localparam int MAX_TAG_BYTES_DEF = 16777216;

	// field widths
	localparam int VERSION_W = 3;
	localparam int LENGTH_W = 25;
	localparam int KEY_W = 32;
	localparam int SIZE_W = 32;
	localparam int FLAGS_W = 16;
	localparam int SKIP_W = 3;
	localparam int HDR_BYTES = 10;
	localparam int HDR_CNT_W = 4;

	// reset value of the version register
	localparam logic [VERSION_W-1:0] VERSION_RESET = 3'd4;
	// version with plain big-endian frame sizes
	localparam logic [VERSION_W-1:0] VERSION_PLAIN = 3'd3;

	// register indexes on the config port
	localparam logic REG_TAG_VERSION = 1'b0;
	localparam logic REG_DATA_LENGTH = 1'b1;

	// frame flag masks
	localparam logic [FLAGS_W-1:0] FL_GROUP = 16'h0040;
	localparam logic [FLAGS_W-1:0] FL_COMPRESSED = 16'h0008;
	localparam logic [FLAGS_W-1:0] FL_ENCRYPTED = 16'h0004;
	localparam logic [FLAGS_W-1:0] FL_UNSYNC = 16'h0002;
	localparam logic [FLAGS_W-1:0] FL_LENGTH = 16'h0001;

	// special byte values
	localparam logic [7:0] BYTE_FF = 8'hff;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	// result kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// stop reasons
	localparam logic [1:0] STOP_NONE = 2'd0;
	localparam logic [1:0] STOP_PADDING = 2'd1;
	localparam logic [1:0] STOP_OVERSIZE = 2'd2;
	localparam logic [1:0] STOP_NO_HEADER = 2'd3;

	// walk phase
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DISCARD,
		PH_PAYLOAD
	} phase_t;

	// one result item
	typedef struct packed {
		logic kind;
		logic [7:0] byte_value;
		logic [KEY_W-1:0] frame_key;
		logic last_of_frame;
		logic [1:0] stop_reason;
	} result_t;

	// status item for a stopped walk
	function automatic result_t status_item(input logic [1:0] reason);
		result_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.stop_reason = reason;
		return r;
	endfunction

	// payload byte item
	function automatic result_t byte_item(input logic [7:0] value, input logic [KEY_W-1:0] key,
			input logic last);
		result_t r;
		r = '0;
		r.kind = KIND_BYTE;
		r.byte_value = value;
		r.frame_key = key;
		r.last_of_frame = last;
		r.stop_reason = STOP_NONE;
		return r;
	endfunction

endpackage

// File: rtl/id3fw_if.sv
// stream interfaces for frame bytes in and walk results out

interface id3fw_in_if;
	logic valid;
	logic ready;
	logic [7:0] byte_in;
	logic first_of_tag;

	modport source (output valid, output byte_in, output first_of_tag, input ready);
	modport sink (input valid, input byte_in, input first_of_tag, output ready);
endinterface

interface id3fw_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] byte_value;
	logic [31:0] frame_key;
	logic last_of_frame;
	logic [1:0] stop_reason;

	modport source (output valid, output kind, output byte_value, output frame_key,
		output last_of_frame, output stop_reason, input ready);
	modport sink (input valid, input kind, input byte_value, input frame_key,
		input last_of_frame, input stop_reason, output ready);
endinterface

// File: rtl/id3v2_frame_walker_unit.sv
// id3v2 frame walker: header parse, skip, frame-level unsync removal, result queue
// a result item is written into the result queue when the byte that causes it is accepted
// throughput: one byte per cycle; a byte may cause two result items, which the 4-entry
// result queue absorbs, and data_ch.ready drops while fewer than two queue slots are free
// reset: arst_n clears the walk state and the queue; tag_version resets to 4, data_length to 0
module id3v2_frame_walker_unit
	import id3fw_pkg::*;
#(
	parameter int MAX_TAG_BYTES = MAX_TAG_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// config port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// streams
	id3fw_in_if.sink data_ch,
	id3fw_out_if.source result_ch
);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// config registers
	logic [VERSION_W-1:0] tag_version_q;
	logic [LENGTH_W-1:0] data_length_q;

	// walk state
	logic [LENGTH_W-1:0] position_q;
	logic [HDR_CNT_W-1:0] header_count_q;
	phase_t phase_q;
	logic [LENGTH_W-1:0] frame_left_q;
	logic [SKIP_W-1:0] skip_left_q;
	logic [FLAGS_W-1:0] frame_flags_q;
	logic [KEY_W-1:0] current_key_q;
	logic prev_ff_q;
	logic [7:0] pending_value_q;
	logic pending_valid_q;
	logic stopped_q;
	logic [7:0] header_q [0:HDR_BYTES-2];

	// working copy after an optional restart
	logic [LENGTH_W-1:0] position_w;
	logic [HDR_CNT_W-1:0] header_count_w;
	phase_t phase_w;
	logic [LENGTH_W-1:0] frame_left_w;
	logic [SKIP_W-1:0] skip_left_w;
	logic prev_ff_w;
	logic pending_valid_w;
	logic stopped_w;

	// next state
	logic [LENGTH_W-1:0] position_d;
	logic [HDR_CNT_W-1:0] header_count_d;
	phase_t phase_d;
	logic [LENGTH_W-1:0] frame_left_d;
	logic [SKIP_W-1:0] skip_left_d;
	logic [FLAGS_W-1:0] frame_flags_d;
	logic [KEY_W-1:0] current_key_d;
	logic prev_ff_d;
	logic [7:0] pending_value_d;
	logic pending_valid_d;
	logic stopped_d;

	// per-byte helpers
	logic in_acc;
	logic restart;
	logic [7:0] b;
	logic [LENGTH_W-1:0] len;
	logic [LENGTH_W-1:0] remain;
	logic [LENGTH_W-1:0] avail;
	logic [SIZE_W-1:0] raw_size;
	logic [SIZE_W-1:0] hdr_size;
	logic [FLAGS_W-1:0] hdr_flags;
	logic [SKIP_W-1:0] hdr_skip;
	logic [LENGTH_W-1:0] left_dec;
	logic last_raw;
	logic hdr_we;
	result_t res0;
	result_t res1;
	logic [1:0] n_wr;

	// result queue
	result_t q_mem [0:QDEPTH-1];
	logic [QPTR_W-1:0] q_head_q;
	logic [QPTR_W-1:0] q_tail_q;
	logic [QCNT_W-1:0] q_count_q;
	logic q_pop;
	logic [QPTR_W-1:0] q_tail_1;

	// config port: pready tied high, register picked by paddr[2]
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DATA_LENGTH) ? {{(32-LENGTH_W){1'b0}}, data_length_q}
		: {{(32-VERSION_W){1'b0}}, tag_version_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_version_q <= VERSION_RESET;
			data_length_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_TAG_VERSION) begin
				tag_version_q <= pwdata[VERSION_W-1:0];
			end else begin
				data_length_q <= pwdata[LENGTH_W-1:0];
			end
		end
	end

	// handshake
	assign data_ch.ready = (q_count_q <= QCNT_W'(QDEPTH - 2));
	assign in_acc = data_ch.valid && data_ch.ready;
	assign restart = in_acc && data_ch.first_of_tag;
	assign b = data_ch.byte_in;

	// effective tag length, clamped
	assign len = ({4'b0, data_length_q} > 29'(MAX_TAG_BYTES)) ? LENGTH_W'(MAX_TAG_BYTES)
		: data_length_q;
	assign remain = len - position_w;
	assign avail = remain - LENGTH_W'(1);

	// frame size and flags from the collected header
	assign raw_size = {header_q[4], header_q[5], header_q[6], header_q[7]};
	assign hdr_size = (tag_version_q == VERSION_PLAIN) ? raw_size
		: {4'b0, raw_size[30:24], raw_size[22:16], raw_size[14:8], raw_size[6:0]};
	assign hdr_flags = {header_q[8], b};
	assign hdr_skip = {(hdr_flags & FL_LENGTH) != '0, 1'b0, (hdr_flags & FL_GROUP) != '0};
	assign left_dec = frame_left_w - LENGTH_W'(1);
	assign last_raw = (left_dec == '0);

	// restart view of the state
	always_comb begin
		if (restart) begin
			position_w = '0;
			header_count_w = '0;
			phase_w = PH_HEADER;
			frame_left_w = '0;
			skip_left_w = '0;
			prev_ff_w = 1'b0;
			pending_valid_w = 1'b0;
			stopped_w = 1'b0;
		end else begin
			position_w = position_q;
			header_count_w = header_count_q;
			phase_w = phase_q;
			frame_left_w = frame_left_q;
			skip_left_w = skip_left_q;
			prev_ff_w = prev_ff_q;
			pending_valid_w = pending_valid_q;
			stopped_w = stopped_q;
		end
	end

	// walk step: next state and up to two result items
	always_comb begin
		position_d = position_w;
		header_count_d = header_count_w;
		phase_d = phase_w;
		frame_left_d = frame_left_w;
		skip_left_d = skip_left_w;
		frame_flags_d = frame_flags_q;
		current_key_d = current_key_q;
		prev_ff_d = prev_ff_w;
		pending_value_d = pending_value_q;
		pending_valid_d = pending_valid_w;
		stopped_d = stopped_w;
		hdr_we = 1'b0;
		res0 = '0;
		res1 = '0;
		n_wr = 2'd0;

		if (in_acc && !stopped_w && (position_w < len)) begin
			if (phase_w == PH_HEADER && header_count_w == '0 && remain < LENGTH_W'(HDR_BYTES))
					begin
				res0 = status_item(STOP_NO_HEADER);
				n_wr = 2'd1;
				stopped_d = 1'b1;
			end else if (phase_w == PH_HEADER && header_count_w == '0 && b == BYTE_ZERO) begin
				res0 = status_item(STOP_PADDING);
				n_wr = 2'd1;
				stopped_d = 1'b1;
			end else begin
				position_d = position_w + LENGTH_W'(1);
				case (phase_w)
					PH_HEADER: begin
						if (header_count_w != HDR_CNT_W'(HDR_BYTES - 1)) begin
							// collect one header byte
							hdr_we = 1'b1;
							header_count_d = header_count_w + HDR_CNT_W'(1);
						end else begin
							// last header byte: decide what to do with the frame
							header_count_d = '0;
							frame_flags_d = hdr_flags;
							if (hdr_size > {{(SIZE_W-LENGTH_W){1'b0}}, avail}) begin
								res0 = status_item(STOP_OVERSIZE);
								n_wr = 2'd1;
								stopped_d = 1'b1;
							end else if (hdr_size == '0) begin
								phase_d = PH_HEADER;
							end else begin
								frame_left_d = hdr_size[LENGTH_W-1:0];
								if ((hdr_flags & (FL_COMPRESSED | FL_ENCRYPTED)) != '0
										|| {{(SIZE_W-SKIP_W){1'b0}}, hdr_skip} >= hdr_size)
										begin
									phase_d = PH_DISCARD;
								end else begin
									current_key_d = {header_q[0], header_q[1], header_q[2],
										header_q[3]};
									skip_left_d = hdr_skip;
									prev_ff_d = 1'b0;
									pending_valid_d = 1'b0;
									phase_d = PH_PAYLOAD;
								end
							end
						end
					end
					PH_DISCARD: begin
						// pass over a frame with no results
						if (frame_left_w != '0) begin
							frame_left_d = left_dec;
						end
						if (frame_left_w == '0 || last_raw) begin
							phase_d = PH_HEADER;
						end
					end
					PH_PAYLOAD: begin
						if (frame_left_w == '0) begin
							phase_d = PH_HEADER;
						end else begin
							frame_left_d = left_dec;
							if (last_raw) begin
								phase_d = PH_HEADER;
							end
							if (skip_left_w != '0) begin
								// group or data length byte
								skip_left_d = skip_left_w - SKIP_W'(1);
							end else if ((frame_flags_q & FL_UNSYNC) != '0 && prev_ff_w
									&& b == BYTE_ZERO) begin
								// drop the stuffed zero, flush the held byte on frame end
								prev_ff_d = 1'b0;
								if (last_raw && pending_valid_w) begin
									res0 = byte_item(pending_value_q, current_key_q, 1'b1);
									n_wr = 2'd1;
									pending_valid_d = 1'b0;
								end
							end else begin
								prev_ff_d = (b == BYTE_FF);
								if (pending_valid_w) begin
									res0 = byte_item(pending_value_q, current_key_q, 1'b0);
									if (last_raw) begin
										res1 = byte_item(b, current_key_q, 1'b1);
										n_wr = 2'd2;
									end else begin
										n_wr = 2'd1;
									end
								end else if (last_raw) begin
									res0 = byte_item(b, current_key_q, 1'b1);
									n_wr = 2'd1;
								end
								if (last_raw) begin
									pending_valid_d = 1'b0;
								end else begin
									pending_value_d = b;
									pending_valid_d = 1'b1;
								end
							end
						end
					end
					default: begin
						phase_d = PH_HEADER;
					end
				endcase
			end
		end
	end

	// walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			header_count_q <= '0;
			phase_q <= PH_HEADER;
			frame_left_q <= '0;
			skip_left_q <= '0;
			frame_flags_q <= '0;
			prev_ff_q <= 1'b0;
			pending_valid_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (in_acc) begin
			position_q <= position_d;
			header_count_q <= header_count_d;
			phase_q <= phase_d;
			frame_left_q <= frame_left_d;
			skip_left_q <= skip_left_d;
			frame_flags_q <= frame_flags_d;
			prev_ff_q <= prev_ff_d;
			pending_valid_q <= pending_valid_d;
			stopped_q <= stopped_d;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			current_key_q <= current_key_d;
			pending_value_q <= pending_value_d;
		end
		if (hdr_we) begin
			header_q[header_count_w] <= b;
		end
	end

	// result queue
	assign q_pop = result_ch.valid && result_ch.ready;
	assign q_tail_1 = q_tail_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (n_wr != 2'd0) begin
			q_mem[q_tail_q] <= res0;
		end
		if (n_wr == 2'd2) begin
			q_mem[q_tail_1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= '0;
			q_tail_q <= '0;
			q_count_q <= '0;
		end else begin
			q_tail_q <= q_tail_q + QPTR_W'(n_wr);
			if (q_pop) begin
				q_head_q <= q_head_q + QPTR_W'(1);
			end
			q_count_q <= q_count_q + QCNT_W'(n_wr) - QCNT_W'(q_pop);
		end
	end

	// output side
	assign result_ch.valid = (q_count_q != '0);
	assign result_ch.kind = q_mem[q_head_q].kind;
	assign result_ch.byte_value = q_mem[q_head_q].byte_value;
	assign result_ch.frame_key = q_mem[q_head_q].frame_key;
	assign result_ch.last_of_frame = q_mem[q_head_q].last_of_frame;
	assign result_ch.stop_reason = q_mem[q_head_q].stop_reason;

	// checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count_q <= QCNT_W'(QDEPTH))
		else $error("result queue overfilled");

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && stopped_q && !data_ch.first_of_tag) |-> (n_wr == 2'd0))
		else $error("stopped walk produced a result");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (frame_left_q != '0))
		else $error("payload phase with no bytes left");

	a_skip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (skip_left_q <= SKIP_W'(5)))
		else $error("skip count out of range");

endmodule

// File: verif/id3v2_frame_walker_unit_tb.sv
// testbench for the id3v2 frame walker: tag streams against a built-in walk model
module id3v2_frame_walker_unit_tb;
	import id3fw_pkg::*;

	localparam int BYTES_WANTED = 1500;
	localparam int HOLD_CYCLES = 300;
	localparam int PRESSURE_TAG = 5;
	localparam int CALM_FIRST = 10;
	localparam int CALM_LAST = 17;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 4;

	// walk model and the queue of results still to come out
	class frame_walk_model;
		logic [VERSION_W-1:0] version;
		logic [LENGTH_W-1:0] length;
		logic [LENGTH_W-1:0] pos;
		logic [7:0] hdr [HDR_BYTES];
		logic [HDR_CNT_W-1:0] hdr_cnt;
		phase_t ph;
		logic [SIZE_W-1:0] bytes_left;
		logic [SKIP_W-1:0] skip_left;
		logic [FLAGS_W-1:0] flags;
		logic [KEY_W-1:0] key;
		logic after_ff;
		logic [7:0] held_value;
		logic held_valid;
		logic halted;
		result_t awaited [$];
		int mismatches;

		function new();
			version = VERSION_RESET;
			length = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			pos = '0;
			foreach (hdr[i]) hdr[i] = '0;
			hdr_cnt = '0;
			ph = PH_HEADER;
			bytes_left = '0;
			skip_left = '0;
			flags = '0;
			key = '0;
			after_ff = 1'b0;
			held_value = '0;
			held_valid = 1'b0;
			halted = 1'b0;
		endfunction

		function void set_reg(logic idx, logic [31:0] value);
			if (idx == REG_TAG_VERSION) version = value[VERSION_W-1:0];
			else length = value[LENGTH_W-1:0];
		endfunction

		function void push_status(logic [1:0] reason);
			result_t r;
			r = '0;
			r.kind = KIND_STATUS;
			r.stop_reason = reason;
			awaited.push_back(r);
			halted = 1'b1;
		endfunction

		function void push_byte(logic [7:0] value, logic last);
			result_t r;
			r = '0;
			r.kind = KIND_BYTE;
			r.byte_value = value;
			r.frame_key = key;
			r.last_of_frame = last;
			r.stop_reason = STOP_NONE;
			awaited.push_back(r);
		endfunction

		// decode a complete header and pick the frame's fate
		function void close_header(logic [LENGTH_W-1:0] avail);
			logic [31:0] raw;
			logic [31:0] fsize;
			logic [SKIP_W-1:0] skip;
			raw = {hdr[4], hdr[5], hdr[6], hdr[7]};
			if (version == VERSION_PLAIN) fsize = raw;
			else fsize = {4'd0, raw[30:24], raw[22:16], raw[14:8], raw[6:0]};
			flags = {hdr[8], hdr[9]};
			hdr_cnt = '0;
			if (fsize > avail) begin
				push_status(STOP_OVERSIZE);
				return;
			end
			if (fsize == 0) begin
				ph = PH_HEADER;
				return;
			end
			skip = '0;
			if ((flags & FL_GROUP) != 0) skip = skip + 3'd1;
			if ((flags & FL_LENGTH) != 0) skip = skip + 3'd4;
			bytes_left = fsize;
			if ((flags & (FL_COMPRESSED | FL_ENCRYPTED)) != 0 || skip >= fsize) begin
				ph = PH_DISCARD;
				return;
			end
			key = {hdr[0], hdr[1], hdr[2], hdr[3]};
			skip_left = skip;
			after_ff = 1'b0;
			held_valid = 1'b0;
			ph = PH_PAYLOAD;
		endfunction

		// one payload byte: skip, unsync removal, one-byte hold for the last mark
		function void take_payload(logic [7:0] b);
			logic last;
			bytes_left = bytes_left - 1;
			last = (bytes_left == 0);
			if (last) ph = PH_HEADER;
			if (skip_left != 0) begin
				skip_left = skip_left - SKIP_W'(1);
				return;
			end
			if ((flags & FL_UNSYNC) != 0 && after_ff && b == BYTE_ZERO) begin
				after_ff = 1'b0;
				if (last && held_valid) begin
					push_byte(held_value, 1'b1);
					held_valid = 1'b0;
				end
				return;
			end
			after_ff = (b == BYTE_FF);
			if (held_valid) push_byte(held_value, 1'b0);
			if (last) begin
				push_byte(b, 1'b1);
				held_valid = 1'b0;
			end else begin
				held_value = b;
				held_valid = 1'b1;
			end
		endfunction

		// note one accepted item and queue what it causes
		function void walk_byte(logic [7:0] b, logic first);
			logic [LENGTH_W-1:0] lim;
			if (first) restart();
			if (halted) return;
			if (length > MAX_TAG_BYTES_DEF) lim = LENGTH_W'(MAX_TAG_BYTES_DEF);
			else lim = length;
			if (pos >= lim) return;
			if (ph == PH_HEADER && hdr_cnt == 0) begin
				if (lim - pos < HDR_BYTES) begin
					push_status(STOP_NO_HEADER);
					return;
				end
				if (b == BYTE_ZERO) begin
					push_status(STOP_PADDING);
					return;
				end
			end
			pos = pos + LENGTH_W'(1);
			case (ph)
				PH_HEADER: begin
					if (hdr_cnt > HDR_BYTES - 1) hdr_cnt = '0;
					hdr[hdr_cnt] = b;
					hdr_cnt = hdr_cnt + HDR_CNT_W'(1);
					if (hdr_cnt == HDR_BYTES) close_header(lim - pos);
				end
				PH_DISCARD: begin
					if (bytes_left != 0) bytes_left = bytes_left - 1;
					if (bytes_left == 0) ph = PH_HEADER;
				end
				default: begin
					if (bytes_left == 0) ph = PH_HEADER;
					else take_payload(b);
				end
			endcase
		endfunction

		function void complain(string msg);
			mismatches++;
			if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
		endfunction

		// compare one result item with the oldest one awaited
		function void match_result(result_t seen);
			result_t want;
			if (awaited.size() == 0) begin
				complain($sformatf("unexpected item kind %0d byte %02h key %08h last %0d reason %0d",
					seen.kind, seen.byte_value, seen.frame_key, seen.last_of_frame,
					seen.stop_reason));
				return;
			end
			want = awaited.pop_front();
			if (seen.kind !== want.kind || seen.byte_value !== want.byte_value ||
					seen.frame_key !== want.frame_key ||
					seen.last_of_frame !== want.last_of_frame ||
					seen.stop_reason !== want.stop_reason)
				complain($sformatf({"expected kind %0d byte %02h key %08h last %0d reason %0d, ",
					"got kind %0d byte %02h key %08h last %0d reason %0d"},
					want.kind, want.byte_value, want.frame_key, want.last_of_frame,
					want.stop_reason, seen.kind, seen.byte_value, seen.frame_key,
					seen.last_of_frame, seen.stop_reason));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	id3fw_in_if data_if ();
	id3fw_out_if res_if ();

	frame_walk_model model = new();
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	int bytes_offered = 0;

	id3v2_frame_walker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.data_ch(data_if),
		.result_ch(res_if)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end

	// result receiver: random stalls, one long hold-off on request
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_if.ready = calm || ($urandom_range(0, 99) >= 36);
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t seen;
		if (arst_n && res_if.valid && res_if.ready) begin
			seen.kind = res_if.kind;
			seen.byte_value = res_if.byte_value;
			seen.frame_key = res_if.frame_key;
			seen.last_of_frame = res_if.last_of_frame;
			seen.stop_reason = res_if.stop_reason;
			model.match_result(seen);
		end
	end

	// wait until every awaited item is out, then let the pipe settle
	task automatic wait_drained();
		int n;
		n = 0;
		while (model.awaited.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (model.awaited.size() != 0) begin
			model.complain($sformatf("%0d items never arrived", model.awaited.size()));
			model.awaited.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// config write: setup then access
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		model.set_reg(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// offer one item, with random gaps, until it is taken
	task automatic send_byte(input logic [7:0] b, input logic first);
		while (!calm && $urandom_range(0, 99) < 36) begin
			data_if.valid = 1'b0;
			@(negedge clk);
		end
		data_if.valid = 1'b1;
		data_if.byte_in = b;
		data_if.first_of_tag = first;
		do @(posedge clk); while (!data_if.ready);
		model.walk_byte(b, first);
		@(negedge clk);
	endtask

	// configure and stream one tag, maybe moving the length partway through
	task automatic send_tag(ref logic [7:0] q[$], input logic [VERSION_W-1:0] ver,
			input logic [LENGTH_W-1:0] len, input bit wild, input bit squeeze);
		int split;
		logic first;
		split = -1;
		if (wild && q.size() > 1 && $urandom_range(0, 9) == 0)
			split = $urandom_range(1, q.size() - 1);
		wait_drained();
		write_reg(REG_TAG_VERSION, 32'(ver));
		write_reg(REG_DATA_LENGTH, 32'(len));
		if (squeeze) hold_request = 1'b1;
		foreach (q[i]) begin
			if (i == split) begin
				data_if.valid = 1'b0;
				wait_drained();
				write_reg(REG_DATA_LENGTH, 32'($urandom_range(0, q.size() + 20)));
			end
			if (i == 0) first = !wild || ($urandom_range(0, 19) != 0);
			else first = wild && ($urandom_range(0, 99) == 0);
			send_byte(q[i], first);
		end
		data_if.valid = 1'b0;
	endtask

	// append one frame: random key, flags and payload rich in ff/00
	function automatic void add_frame(ref logic [7:0] q[$], input logic [VERSION_W-1:0] ver,
			input bit plain);
		logic [FLAGS_W-1:0] fl;
		logic [31:0] raw;
		logic [27:0] n28;
		logic [3:0] top;
		int skip;
		int n;
		int r;
		q.push_back(8'($urandom_range(1, 255)));
		repeat (3) q.push_back(8'($urandom));
		if (plain) fl = $urandom_range(0, 1) ? FL_UNSYNC : '0;
		else fl = 16'($urandom);
		if (!plain && $urandom_range(0, 3) != 0) fl = fl & ~(FL_COMPRESSED | FL_ENCRYPTED);
		skip = ((fl & FL_GROUP) != 0 ? 1 : 0) + ((fl & FL_LENGTH) != 0 ? 4 : 0);
		r = $urandom_range(0, 9);
		if (plain) n = skip + $urandom_range(6, 12);
		else if (r == 0) n = 0;
		else if (r == 1) n = skip;
		else n = skip + $urandom_range(1, 12);
		n28 = 28'(n);
		top = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd0;
		if (ver == VERSION_PLAIN) raw = 32'(n);
		else raw = {top[3], n28[27:21], top[2], n28[20:14], top[1], n28[13:7], top[0], n28[6:0]};
		// occasional wild size, almost always oversize
		if (!plain && $urandom_range(0, 19) == 0) begin
			raw = $urandom;
			n = $urandom_range(0, 4);
		end
		q.push_back(raw[31:24]);
		q.push_back(raw[23:16]);
		q.push_back(raw[15:8]);
		q.push_back(raw[7:0]);
		q.push_back(fl[15:8]);
		q.push_back(fl[7:0]);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: q.push_back(BYTE_FF);
				1: q.push_back(BYTE_ZERO);
				default: q.push_back(8'($urandom));
			endcase
		end
	endfunction

	// build one random tag with a chosen ending and stream it
	task automatic random_tag(input int tag_no);
		logic [7:0] q[$];
		logic [VERSION_W-1:0] ver;
		logic [LENGTH_W-1:0] len;
		bit plain;
		int shape;
		int r;
		plain = (tag_no == PRESSURE_TAG);
		calm = (tag_no >= CALM_FIRST && tag_no <= CALM_LAST);
		r = $urandom_range(0, 9);
		if (tag_no == 0) ver = '0;
		else if (tag_no == 1) ver = '1;
		else if (r < 4) ver = VERSION_PLAIN;
		else if (r < 8) ver = VERSION_RESET;
		else ver = 3'($urandom);
		repeat ($urandom_range(1, 5)) add_frame(q, ver, plain);
		shape = plain ? 0 : $urandom_range(0, 99);
		if (shape < 50) begin
			len = LENGTH_W'(q.size());
		end else if (shape < 62) begin
			// padding, or too short a tail for a header
			repeat ($urandom_range(1, 14)) q.push_back(BYTE_ZERO);
			len = LENGTH_W'(q.size());
		end else if (shape < 74) begin
			repeat ($urandom_range(1, 9)) q.push_back(8'($urandom));
			len = LENGTH_W'(q.size());
		end else if (shape < 84) begin
			// cut short, trailing items past the length
			len = LENGTH_W'($urandom_range(0, q.size()));
			repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
		end else if (shape < 92) begin
			if ($urandom_range(0, 1) != 0) len = '1;
			else len = LENGTH_W'(q.size() + $urandom_range(10, 1000));
		end else begin
			// noise
			q.delete();
			repeat ($urandom_range(1, 40)) q.push_back(8'($urandom));
			len = LENGTH_W'($urandom_range(0, 50));
		end
		if (tag_no == 2) len = '1;
		if (tag_no == 3) len = '0;
		send_tag(q, ver, len, !plain, plain);
		bytes_offered += q.size();
	endtask

	// main sequence
	initial begin
		logic [7:0] q[$];
		int tag_no;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		data_if.valid = 1'b0;
		data_if.byte_in = '0;
		data_if.first_of_tag = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// header does not fit
		q = '{BYTE_FF};
		send_tag(q, VERSION_RESET, 25'd3, 1'b0, 1'b0);
		// padding, then an item on a stopped walk
		q = '{BYTE_ZERO, BYTE_FF};
		send_tag(q, VERSION_RESET, 25'd20, 1'b0, 1'b0);
		// oversize frame with a plain size
		q = '{8'h54, 8'h49, 8'h54, 8'h32, BYTE_FF, BYTE_FF, BYTE_FF, BYTE_FF,
			BYTE_ZERO, BYTE_ZERO};
		send_tag(q, VERSION_PLAIN, 25'd15, 1'b0, 1'b0);
		// unsync frame whose last raw byte is a dropped zero
		q = '{8'h54, 8'h58, 8'h58, 8'h58, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, 8'h02,
			BYTE_ZERO, FL_UNSYNC[7:0], BYTE_FF, BYTE_ZERO};
		send_tag(q, VERSION_RESET, 25'd12, 1'b0, 1'b0);

		tag_no = 0;
		while (bytes_offered < BYTES_WANTED) begin
			random_tag(tag_no);
			tag_no++;
		end
		calm = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (model.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/id3fw_pkg.sv
rtl/id3fw_if.sv
rtl/id3v2_frame_walker_unit.sv
verif/id3v2_frame_walker_unit_tb.sv
